FILE: rtl/salloc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_pkg: shared types and constants of the slot allocator
// Request and status codes, queue item and result records, sequencer states
// and the bit layout of the stream payloads.
// ----------------------------------------------------------------------------
package salloc_pkg;

  // Store geometry
  localparam int SLOTS       = 256;
  localparam int VALUE_BITS  = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);

  // Compact-index counting: one chunk of free flags per cycle
  localparam int CHUNK_W     = 64;
  localparam int CHUNK_BIT_W = $clog2(CHUNK_W);
  localparam int N_CHUNKS    = SLOTS / CHUNK_W;
  localparam int CHUNK_IDX_W = SLOT_W - CHUNK_BIT_W;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths on the stream ports
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int SLOT_F_W    = 8;
  localparam int VALUE_F_W   = 32;
  localparam int COUNT_F_W   = 9;

  // Input beat layout
  localparam int IN_REQ_LSB   = 0;
  localparam int IN_SLOT_LSB  = IN_REQ_LSB + REQ_W;
  localparam int IN_VALUE_LSB = IN_SLOT_LSB + SLOT_F_W;
  localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_F_W;
  localparam int IN_W         = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout
  localparam int OUT_USED_W   = STATUS_W + SLOT_F_W + VALUE_F_W + 1 + SLOT_F_W
                                + COUNT_F_W + COUNT_F_W;
  localparam int OUT_W        = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_W - OUT_USED_W;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_READ    = 2'd2,
    OP_COMPACT = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEM,
    ST_CNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic [SLOT_W-1:0]     slot;
    logic [VALUE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot_out;
    logic [VALUE_BITS-1:0] read_value;
    logic                  live;
    logic [SLOT_W-1:0]     compact_index;
    logic [CNT_W-1:0]      live_count;
    logic [CNT_W-1:0]      high_water;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/salloc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_front: request intake
// Accepts request beats, unpacks and classifies them into queue items and
// pushes them into the request queue while it has room.
// ----------------------------------------------------------------------------
module salloc_front (
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [salloc_pkg::IN_W-1:0] in_tdata,  // req_type, slot, value
  input  wire logic                    q_full,
  output logic                         q_push,
  output salloc_pkg::item_t            q_item
);
  import salloc_pkg::*;

  // Take a beat whenever the queue has a free entry
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Unpack and classify the request
  always_comb begin
    q_item.op    = op_t'(in_tdata[IN_REQ_LSB +: REQ_W]);
    q_item.slot  = SLOT_W'(in_tdata[IN_SLOT_LSB +: SLOT_F_W]);
    q_item.value = VALUE_BITS'(in_tdata[IN_VALUE_LSB +: VALUE_F_W]);
  end

endmodule
`default_nettype wire

FILE: rtl/salloc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_fifo: request queue
// Short first-in-first-out queue that decouples request intake from the
// execution sequencer.
// ----------------------------------------------------------------------------
module salloc_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire salloc_pkg::item_t wr_item,
  input  wire logic              pop,
  output logic                   full,
  output logic                   valid,
  output salloc_pkg::item_t      rd_item
);
  import salloc_pkg::*;

  item_t                  entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_item = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("request queue occupancy out of range");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue push lost");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree while empty");

endmodule
`default_nettype wire

FILE: rtl/salloc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_back: execution sequencer
// Takes one request at a time from the queue, reads the element and free
// stack memories, counts free flags for compact requests, commits the state
// update and loads the result register.
// ----------------------------------------------------------------------------
module salloc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire salloc_pkg::item_t q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output salloc_pkg::result_t    out_res
);
  import salloc_pkg::*;

  state_t                 state_r, state_nxt;
  item_t                  item_r;
  logic                   live_r;
  logic [CNT_W-1:0]       hwm_r, hwm_nxt;
  logic [CNT_W-1:0]       fc_r, fc_nxt;
  logic [SLOTS-1:0]       flags_r;
  logic [CNT_W-1:0]       freed_r;
  logic [CHUNK_IDX_W-1:0] chunk_r;
  logic                   out_valid_r;
  result_t                out_r;

  logic [VALUE_BITS-1:0]  store_mem [SLOTS];
  logic [VALUE_BITS-1:0]  store_q;
  logic [SLOT_W-1:0]      stack_mem [SLOTS];
  logic [SLOT_W-1:0]      stack_q;

  logic                   out_free, commit, cnt_last;
  logic                   store_we, stack_we, flag_we, flag_val;
  logic [SLOT_W-1:0]      store_waddr, flag_idx;
  logic [CHUNK_W-1:0]     chunk_bits;
  logic [CNT_W-1:0]       chunk_cnt;
  result_t                res;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (item_r.op == OP_COMPACT) ? ST_CNT : ST_MEM;
      ST_MEM:  state_nxt = ST_DONE;
      ST_CNT:  if (cnt_last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop  = q_valid;
      ST_DONE: commit = out_free;
      default: ;
    endcase
    cnt_last = (chunk_r == CHUNK_IDX_W'(N_CHUNKS - 1));
  end

  // Mask one chunk of free flags to slots at or below the requested one
  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      chunk_bits[j] = flags_r[{chunk_r, CHUNK_BIT_W'(j)}]
                      && ({chunk_r, CHUNK_BIT_W'(j)} <= item_r.slot);
    end
    chunk_cnt = CNT_W'($countones(chunk_bits));
  end

  // Work out the state update and the result of the current request
  always_comb begin
    res         = '0;
    res.status  = STAT_OK;
    hwm_nxt     = hwm_r;
    fc_nxt      = fc_r;
    store_we    = 1'b0;
    stack_we    = 1'b0;
    flag_we     = 1'b0;
    flag_val    = 1'b0;
    store_waddr = stack_q;
    flag_idx    = item_r.slot;
    case (item_r.op)
      OP_ADD: begin
        if (fc_r != '0) begin
          // reuse the most recently freed slot
          fc_nxt       = fc_r - 1'b1;
          store_waddr  = stack_q;
          flag_idx     = stack_q;
          store_we     = commit;
          flag_we      = commit;
          res.slot_out = stack_q;
        end else if (hwm_r < CNT_W'(SLOTS)) begin
          // extend at the high-water mark
          hwm_nxt      = hwm_r + 1'b1;
          store_waddr  = hwm_r[SLOT_W-1:0];
          store_we     = commit;
          res.slot_out = hwm_r[SLOT_W-1:0];
        end else begin
          res.status   = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (live_r) begin
          flag_we  = commit;
          flag_val = 1'b1;
          stack_we = commit;
          fc_nxt   = fc_r + 1'b1;
        end else begin
          res.status = STAT_BAD;
        end
      end
      OP_READ: begin
        if (live_r) begin
          res.live       = 1'b1;
          res.read_value = store_q;
        end
      end
      default: begin
        if (live_r) begin
          res.live          = 1'b1;
          res.compact_index = item_r.slot - freed_r[SLOT_W-1:0];
        end else begin
          res.status = STAT_BAD;
        end
      end
    endcase
    res.live_count = hwm_nxt - fc_nxt;
    res.high_water = hwm_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hwm_r       <= '0;
      fc_r        <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        hwm_r <= hwm_nxt;
        fc_r  <= fc_nxt;
      end
      if (flag_we) begin
        flags_r[flag_idx] <= flag_val;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, liveness, free-flag count and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == ST_EXEC) begin
      live_r  <= (CNT_W'(item_r.slot) < hwm_r) && !flags_r[item_r.slot];
      freed_r <= '0;
      chunk_r <= '0;
    end else if (state_r == ST_CNT) begin
      freed_r <= freed_r + chunk_cnt;
      chunk_r <= chunk_r + 1'b1;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  // Element store: write on commit, read the requested slot
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= item_r.value;
    end
    store_q <= store_mem[item_r.slot];
  end

  // Free stack: push on remove, read the top entry
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[fc_r[SLOT_W-1:0]] <= item_r.slot;
    end
    stack_q <= stack_mem[SLOT_W'(fc_r - 1'b1)];
  end

  a_hwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r <= CNT_W'(SLOTS))
    else $error("high-water mark beyond store size");

  a_fc_le_hwm: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= hwm_r)
    else $error("more free slots than slots in use");

  a_remove_push: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && item_r.op == OP_REMOVE && live_r) |=> fc_r == $past(fc_r) + 1'b1)
    else $error("remove did not push the slot");

  a_add_live: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && item_r.op == OP_ADD && res.status == STAT_OK)
    |=> !flags_r[$past(res.slot_out)])
    else $error("added slot still flagged free");

endmodule
`default_nettype wire

FILE: rtl/slot_allocator_with_free_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_allocator_with_free_stack: slot store with a last-in-first-out free list
// Stores values at stable slot indices, reuses freed slots most recent first
// and answers add, remove, read and compact-index requests.
// ----------------------------------------------------------------------------
// One result beat per request beat, in request order. Requests enter a
// two-entry queue and are executed one at a time by a sequencer: add, remove
// and read go through dequeue, liveness check, registered memory read and
// commit; a compact-index request replaces the memory read by counting the
// free flags, 64 per cycle. Output back-pressure holds the sequencer in its
// commit cycle. Free flags are cleared at reset; the element and free-stack
// memories need no clearing pass, so the block takes requests right after
// reset. Status is 0 ok, 1 store full on add, 2 slot free or out of range on
// remove or compact.
// ----------------------------------------------------------------------------
module slot_allocator_with_free_stack (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [salloc_pkg::IN_W-1:0]  in_tdata,   // req_type, slot, value
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [salloc_pkg::OUT_W-1:0]      out_tdata   // status, slot_out, read_value,
                                                        // live, compact_index,
                                                        // live_count, high_water
);
  import salloc_pkg::*;

  logic       q_push, q_full, q_valid, q_pop;
  item_t      in_item, q_item;
  result_t    res;

  salloc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (in_item)
  );

  salloc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (in_item),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (q_item)
  );

  salloc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Pack the result beat, first field in the lowest bits
  assign out_tdata = {
    {OUT_PAD_W{1'b0}},
    COUNT_F_W'(res.high_water),
    COUNT_F_W'(res.live_count),
    SLOT_F_W'(res.compact_index),
    res.live,
    VALUE_F_W'(res.read_value),
    SLOT_F_W'(res.slot_out),
    STATUS_W'(res.status)
  };

endmodule
`default_nettype wire
